// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the XOR k-bucket table update module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define KBT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("Assertion failed.");
`define KBT_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("Assertion failed during or after reset.");
`else
`define KBT_ASSERT(label, prop)
`define KBT_ASSERT_RST(label, prop)
`endif

`endif

// ===== rtl/kbt_pkg.sv =====
// ----------------------------------------------------------------------------
// K-bucket table package
// Shared types and fixed field widths of the k-bucket table update block.
// ----------------------------------------------------------------------------
package kbt_pkg;

   localparam int ID_W     = 32;
   localparam int BUCKET_W = 6;
   localparam int FILL_W   = 4;

   typedef enum logic {
      S_IDLE,
      S_READ
   } kbt_state_type;

   typedef struct packed {
      logic hit;
      logic evict;
   } kbt_status_type;

endpackage

// ===== rtl/kbt_row_ram.sv =====
// ----------------------------------------------------------------------------
// K-bucket row memory
// Simple dual-port synchronous memory with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module kbt_row_ram #(
   parameter int ROWS   = 33,
   parameter int WIDTH  = 260,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] row_mem [ROWS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kbt_row_update.sv =====
// ----------------------------------------------------------------------------
// K-bucket row update
// Compares an identifier against every filled entry of one bucket row, then moves
// it to the front on a hit or pushes it to the front on a miss, evicting the
// tail entry when the row is full.
// ----------------------------------------------------------------------------
module kbt_row_update #(
   parameter int ID_BITS      = 32,
   parameter int BUCKET_DEPTH = 8,
   parameter int CNT_W        = 4
) (
   input  logic [BUCKET_DEPTH-1:0][ID_BITS-1:0] row_entries,
   input  logic [CNT_W-1:0]                     row_cnt,
   input  logic [ID_BITS-1:0]                   node_id,
   output logic [BUCKET_DEPTH-1:0][ID_BITS-1:0] new_entries,
   output logic [CNT_W-1:0]                     new_cnt,
   output logic [ID_BITS-1:0]                   evicted_id,
   output kbt_pkg::kbt_status_type              status
);

   import kbt_pkg::*;

   localparam int IDX_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;

   logic [BUCKET_DEPTH-1:0] hit_vec;
   logic [IDX_W-1:0]        hit_pos;
   logic [CNT_W-1:0]        shift_limit;
   logic                    hit;
   logic                    full;

   always_comb begin
      hit_vec = '0;
      for (int k = 0; k < BUCKET_DEPTH; k++) begin
         hit_vec[k] = (CNT_W'(k) < row_cnt) && (row_entries[k] == node_id);
      end
      hit_pos = '0;
      for (int k = BUCKET_DEPTH - 1; k >= 0; k--) begin
         if (hit_vec[k]) begin
            hit_pos = IDX_W'(k);
         end
      end
      hit  = |hit_vec;
      full = (row_cnt >= CNT_W'(BUCKET_DEPTH));

      if (hit) begin
         shift_limit = CNT_W'(hit_pos);
      end else if (full) begin
         shift_limit = CNT_W'(BUCKET_DEPTH - 1);
      end else begin
         shift_limit = row_cnt;
      end

      new_entries    = row_entries;
      new_entries[0] = node_id;
      for (int k = 1; k < BUCKET_DEPTH; k++) begin
         if (CNT_W'(k) <= shift_limit) begin
            new_entries[k] = row_entries[k-1];
         end
      end

      status.hit   = hit;
      status.evict = !hit && full;
      evicted_id   = status.evict ? row_entries[BUCKET_DEPTH-1] : '0;
      new_cnt      = (hit || full) ? row_cnt : row_cnt + CNT_W'(1);
   end

endmodule

// ===== rtl/xor_kbucket_table_update.sv =====
// ----------------------------------------------------------------------------
// XOR k-bucket table update
// An accepted request reads its bucket row, and the updated row is written
// back as the result is registered; no new request is taken until then. A
// stalled result holds the block in its read state, delaying the write-back.
// Reset clears every bucket count through per-bucket valid bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xor_kbucket_table_update #(
   parameter int ID_BITS      = 32,
   parameter int BUCKET_DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kbt_pkg::ID_W-1:0]      req_node_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kbt_pkg::BUCKET_W-1:0]  rsp_bucket_index,
   output logic                          rsp_was_present,
   output logic                          rsp_did_evict,
   output logic [kbt_pkg::ID_W-1:0]      rsp_evicted_id,
   output logic [kbt_pkg::FILL_W-1:0]    rsp_bucket_fill,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kbt_pkg::ID_W-1:0]      csr_own_id
);

   import kbt_pkg::*;

   localparam int NUM_BUCKETS = ID_BITS + 1;
   localparam int BKT_W       = $clog2(NUM_BUCKETS);
   localparam int CNT_W       = $clog2(BUCKET_DEPTH + 1);
   localparam int ENTRY_W     = BUCKET_DEPTH * ID_BITS;
   localparam int ROW_W       = ENTRY_W + CNT_W;

   kbt_state_type state_ff, state_in;

   logic [ID_W-1:0]        own_id_ff;
   logic [ID_BITS-1:0]     id_ff;
   logic [BKT_W-1:0]       bucket_ff;
   logic [BKT_W-1:0]       bucket_in;
   logic [ID_BITS-1:0]     xor_dist;
   logic [NUM_BUCKETS-1:0] row_valid_ff;

   logic                   rd_en;
   logic                   wr_en;
   logic                   rsp_load;
   logic [ROW_W-1:0]       rd_data;

   logic [BUCKET_DEPTH-1:0][ID_BITS-1:0] row_entries;
   logic [BUCKET_DEPTH-1:0][ID_BITS-1:0] new_entries;
   logic [CNT_W-1:0]       row_cnt;
   logic [CNT_W-1:0]       new_cnt;
   logic [ID_BITS-1:0]     evicted;
   kbt_status_type         status;

   logic                   rsp_valid_ff;
   logic [BUCKET_W-1:0]    rsp_bucket_ff;
   logic                   rsp_hit_ff;
   logic                   rsp_evict_ff;
   logic [ID_W-1:0]        rsp_evicted_ff;
   logic [FILL_W-1:0]      rsp_fill_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         own_id_ff <= csr_own_id;
      end
   end

   always_comb begin
      xor_dist  = req_node_id[ID_BITS-1:0] ^ own_id_ff[ID_BITS-1:0];
      bucket_in = '0;
      for (int k = 0; k < ID_BITS; k++) begin
         if (xor_dist[k]) begin
            bucket_in = BKT_W'(k + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rd_en    = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (!rsp_valid_ff || rsp_ready) begin
               wr_en    = 1'b1;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         id_ff     <= req_node_id[ID_BITS-1:0];
         bucket_ff <= bucket_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[bucket_ff] <= 1'b1;
      end
   end

   kbt_row_ram #(
      .ROWS   (NUM_BUCKETS),
      .WIDTH  (ROW_W),
      .ADDR_W (BKT_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (bucket_ff),
      .wr_data ({new_cnt, new_entries}),
      .rd_en   (rd_en),
      .rd_addr (bucket_in),
      .rd_data (rd_data)
   );

   assign row_entries = rd_data[ENTRY_W-1:0];
   assign row_cnt     = row_valid_ff[bucket_ff] ? rd_data[ROW_W-1 -: CNT_W] : '0;

   kbt_row_update #(
      .ID_BITS      (ID_BITS),
      .BUCKET_DEPTH (BUCKET_DEPTH),
      .CNT_W        (CNT_W)
   ) u_row_update (
      .row_entries (row_entries),
      .row_cnt     (row_cnt),
      .node_id     (id_ff),
      .new_entries (new_entries),
      .new_cnt     (new_cnt),
      .evicted_id  (evicted),
      .status      (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_bucket_ff  <= BUCKET_W'(bucket_ff);
         rsp_hit_ff     <= status.hit;
         rsp_evict_ff   <= status.evict;
         rsp_evicted_ff <= ID_W'(evicted);
         rsp_fill_ff    <= FILL_W'(new_cnt);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = rsp_bucket_ff;
   assign rsp_was_present  = rsp_hit_ff;
   assign rsp_did_evict    = rsp_evict_ff;
   assign rsp_evicted_id   = rsp_evicted_ff;
   assign rsp_bucket_fill  = rsp_fill_ff;

   `KBT_ASSERT(a_accept_reads, (req_valid && req_ready) |=> (state_ff == S_READ))
   `KBT_ASSERT(a_no_overlap, wr_en |-> !req_ready)
   `KBT_ASSERT(a_wr_cnt_range, wr_en |-> (new_cnt != '0 && new_cnt <= CNT_W'(BUCKET_DEPTH)))
   `KBT_ASSERT(a_evict_excl_hit, rsp_valid_ff |-> !(rsp_evict_ff && rsp_hit_ff))
   `KBT_ASSERT_RST(a_reset_idle, $past(reset) |-> (state_ff == S_IDLE && !rsp_valid_ff))

endmodule

// ===== bench/tb_xor_kbucket_table_update.sv =====
// ----------------------------------------------------------------------------
// XOR k-bucket table update testbench
// Sends contact identifiers through the request channel and predicts each
// response from a bucket-list model kept alongside the block. Directed
// contacts cover the bucket extremes, refreshes, evictions and the node's own
// identifier. Random phases then run under several own identifiers and
// idling patterns, and one phase holds off responses until the block stalls.
// ----------------------------------------------------------------------------
module tb_xor_kbucket_table_update;
   import kbt_pkg::*;

   localparam int ID_BITS = 32;
   localparam int DEPTH   = 8;
   localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - ID_BITS);

   typedef struct packed {
      logic [BUCKET_W-1:0] bucket;
      logic                present;
      logic                evict;
      logic [ID_W-1:0]     victim;
      logic [FILL_W-1:0]   fill;
   } kbucket_result_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [ID_W-1:0]     req_node_id = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [BUCKET_W-1:0] rsp_bucket_index;
   logic                rsp_was_present;
   logic                rsp_did_evict;
   logic [ID_W-1:0]     rsp_evicted_id;
   logic [FILL_W-1:0]   rsp_bucket_fill;
   logic                csr_valid   = 1'b0;
   logic                csr_ready;
   logic [ID_W-1:0]     csr_own_id  = '0;

   logic [ID_W-1:0] own_id_model;
   logic [ID_W-1:0] bucket_rows [0:ID_BITS][0:DEPTH-1];
   int              bucket_fills [0:ID_BITS];
   kbucket_result_type pending_results [$];
   logic [ID_W-1:0] recent_ids [$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_len     = 0;
   int hold_seq     = 0;
   int hold_seen    = 0;
   int hold_left    = 0;

   int n_errors   = 0;
   int n_results  = 0;
   int n_refresh  = 0;
   int n_evicted  = 0;
   int n_settings = 0;

   xor_kbucket_table_update #(
      .ID_BITS      (ID_BITS),
      .BUCKET_DEPTH (DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_node_id      (req_node_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_was_present  (rsp_was_present),
      .rsp_did_evict    (rsp_did_evict),
      .rsp_evicted_id   (rsp_evicted_id),
      .rsp_bucket_fill  (rsp_bucket_fill),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_own_id       (csr_own_id)
   );

   always #5 clock = ~clock;

   function automatic kbucket_result_type update_bucket(input logic [ID_W-1:0] node);
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] xor_dist;
      kbucket_result_type r;
      int b;
      int cnt;
      int pos;
      int k;
      id       = node & ID_MASK;
      xor_dist = (id ^ own_id_model) & ID_MASK;
      b        = 0;
      for (k = 0; k < ID_W; k++) begin
         if (xor_dist[k]) begin
            b = k + 1;
         end
      end
      cnt = bucket_fills[b];
      pos = cnt;
      r   = '0;
      for (k = cnt - 1; k >= 0; k--) begin
         if (bucket_rows[b][k] == id) begin
            pos = k;
         end
      end
      if (pos < cnt) begin
         r.present = 1'b1;
         for (k = pos; k > 0; k--) begin
            bucket_rows[b][k] = bucket_rows[b][k-1];
         end
      end else begin
         if (cnt >= DEPTH) begin
            r.evict  = 1'b1;
            r.victim = bucket_rows[b][cnt-1];
            cnt--;
         end
         for (k = cnt; k > 0; k--) begin
            bucket_rows[b][k] = bucket_rows[b][k-1];
         end
         cnt++;
      end
      bucket_rows[b][0] = id;
      bucket_fills[b]   = cnt;
      r.bucket = BUCKET_W'(b);
      r.fill   = FILL_W'(cnt);
      return r;
   endfunction

   // Contacts favor recently seen identifiers and a few crowded buckets so
   // that refreshes and evictions are frequent.
   function automatic logic [ID_W-1:0] pick_contact();
      logic [ID_W-1:0] xor_dist;
      int mode;
      int b;
      mode = $urandom_range(99);
      if (mode < 45 && recent_ids.size() > 0) begin
         return recent_ids[$urandom_range(recent_ids.size() - 1)];
      end
      if (mode >= 95) begin
         return $urandom;
      end
      b = (mode < 80) ? $urandom_range(7, 5) : $urandom_range(ID_BITS, 0);
      xor_dist = '0;
      if (b > 0) begin
         xor_dist[b-1] = 1'b1;
         xor_dist      = xor_dist | ($urandom & (xor_dist - 1));
      end
      return (own_id_model ^ xor_dist) & ID_MASK;
   endfunction

   task automatic report_mismatch(input string field, input logic [ID_W-1:0] got,
                                  input logic [ID_W-1:0] want);
      $display("ERROR: response %0d, %s: got 0x%0h, expected 0x%0h",
               n_results, field, got, want);
      n_errors++;
   endtask

   task automatic send_contact(input logic [ID_W-1:0] node);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid   <= 1'b1;
      req_node_id <= node;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(update_bucket(node));
      recent_ids.push_back(node & ID_MASK);
      if (recent_ids.size() > 24) begin
         void'(recent_ids.pop_front());
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_own_id(input logic [ID_W-1:0] value);
      csr_valid  <= 1'b1;
      csr_own_id <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      own_id_model  = value;
      n_settings++;
   endtask

   task automatic test_directed_cases();
      logic [ID_W-1:0] own;
      int k;
      own = 32'h5A5A_5A5A;
      write_own_id(own);
      send_contact(own);
      send_contact(own);
      send_contact(own ^ 32'h1);
      send_contact(own ^ 32'h8000_0000);
      send_contact(~own);
      send_contact(32'h0000_0000);
      send_contact(32'hFFFF_FFFF);
      for (k = 0; k <= DEPTH; k++) begin
         send_contact(own ^ (32'h10 + k));
      end
      send_contact(own ^ 32'h11);
      send_contact(own ^ 32'h10);
      send_contact(own ^ (32'h10 + DEPTH));
      wait_idle();
   endtask

   task automatic test_random_contacts(input logic [ID_W-1:0] own, input int req_pct,
                                       input int rsp_pct, input int count);
      write_own_id(own);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (count) begin
         send_contact(pick_contact());
      end
      wait_idle();
   endtask

   task automatic test_result_backpressure();
      write_own_id($urandom);
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      hold_len     <= 80;
      hold_seq     <= hold_seq + 1;
      repeat (30) begin
         send_contact(pick_contact());
      end
      wait_idle();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= hold_len;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      kbucket_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transaction, bucket_index",
                            ID_W'(rsp_bucket_index), '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bucket_index !== want.bucket) begin
               report_mismatch("bucket_index", ID_W'(rsp_bucket_index),
                               ID_W'(want.bucket));
            end
            if (rsp_was_present !== want.present) begin
               report_mismatch("was_present", ID_W'(rsp_was_present),
                               ID_W'(want.present));
            end
            if (rsp_did_evict !== want.evict) begin
               report_mismatch("did_evict", ID_W'(rsp_did_evict), ID_W'(want.evict));
            end
            if (rsp_evicted_id !== want.victim) begin
               report_mismatch("evicted_id", rsp_evicted_id, want.victim);
            end
            if (rsp_bucket_fill !== want.fill) begin
               report_mismatch("bucket_fill", ID_W'(rsp_bucket_fill), ID_W'(want.fill));
            end
            n_refresh += int'(want.present);
            n_evicted += int'(want.evict);
         end
      end
   end

   initial begin
      kbucket_result_type leftover;
      own_id_model = '0;
      for (int b = 0; b <= ID_BITS; b++) begin
         bucket_fills[b] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_contacts(32'h0000_0000, 9, 86, 180);
      test_random_contacts(32'hFFFF_FFFF, 86, 9, 180);
      test_random_contacts($urandom, 0, 0, 150);
      test_result_backpressure();
      repeat (8) @(posedge clock);
      while (pending_results.size() != 0) begin
         leftover = pending_results.pop_front();
         report_mismatch("missing transaction, bucket_index", '0, ID_W'(leftover.bucket));
      end
      $display("Checked %0d responses under %0d own identifiers.", n_results, n_settings);
      $display("Contacts refreshed: %0d, tail entries evicted: %0d.", n_refresh, n_evicted);
      if (n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout waiting for the block.");
      $display("Mismatches found");
      $finish;
   end

endmodule
